@@ design/round_robin_thread_scheduler_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Round-robin thread scheduler: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared types, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int unsigned MaxThreads = 32;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_DELAY = 2'd1,
    FUNC_SCHED = 2'd2
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] delay_ticks;
  } item_t;

  typedef struct packed {
    logic [5:0]  next_thread;
    logic        switch_request;
    logic [31:0] ready_bits;
  } result_t;

  typedef struct packed {
    logic tick_start;
    logic tick_step;
    logic delay_apply;
    logic sched_step;
    logic sw_clear;
  } cmd_t;

  typedef struct packed {
    logic multi_thread;
    logic tick_last;
    logic delay_ok;
    logic sched_done;
  } stat_t;

endpackage

`default_nettype wire

@@ design/rrts_ctrl.sv @@
// ----------------------------------------------------------------------------
// Round-robin thread scheduler controller
// One-hot sequencer for the tick walk, delay and round-robin search.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  rrts_pkg::func_e     func_i,
  input  rrts_pkg::stat_t     stat_i,
  output rrts_pkg::cmd_t      cmd_o,
  output logic                busy,
  output logic                strobe_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TICK  = 4'b0010,
    ST_SCHED = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (func_i)
            rrts_pkg::FUNC_TICK: begin
              cmd_o.tick_start = 1'b1;
              cmd_o.sw_clear   = 1'b1;
              state_d = stat_i.multi_thread ? ST_TICK : ST_DONE;
            end
            rrts_pkg::FUNC_DELAY: begin
              if (stat_i.delay_ok) begin
                cmd_o.delay_apply = 1'b1;
                state_d = ST_SCHED;
              end else begin
                cmd_o.sw_clear = 1'b1;
                state_d = ST_DONE;
              end
            end
            rrts_pkg::FUNC_SCHED: begin
              state_d = ST_SCHED;
            end
            default: begin
              cmd_o.sw_clear = 1'b1;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (stat_i.tick_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SCHED: begin
        cmd_o.sched_step = 1'b1;
        if (stat_i.sched_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

@@ design/rrts_dp.sv @@
// ----------------------------------------------------------------------------
// Round-robin thread scheduler datapath
// Thread count, ready mask, timeout counters and the selection registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_dp #(
  parameter int unsigned MAX_THREADS = rrts_pkg::MaxThreads
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [5:0]     cfg_wdata_i,
  input  wire logic [31:0]    delay_ticks_i,
  input  rrts_pkg::cmd_t      cmd_i,
  output rrts_pkg::stat_t     stat_o,
  output rrts_pkg::result_t   result_o
);

  localparam int unsigned IdxW = $clog2(MAX_THREADS);
  localparam logic [5:0]  NMax = 6'(MAX_THREADS + 1);

  logic [5:0]  cnt_q;
  logic [31:0] ready_q, ready_d;
  logic [31:0] tmo_q [MAX_THREADS];
  logic [5:0]  sel_q;
  logic [5:0]  run_q;
  logic        rv_q;
  logic        sw_q;
  logic [5:0]  walk_q;

  logic [5:0]  n;
  logic [5:0]  k;
  logic [31:0] started;
  logic [31:0] ready_eff;
  logic [6:0]  sel_inc;
  logic [5:0]  cand;
  logic [5:0]  cand_m1;
  logic        hit;
  logic        none_ready;
  logic [5:0]  sel_new;
  logic [5:0]  walk_m1;
  logic [5:0]  run_m1;
  logic [31:0] tmo_rd;

  always_comb begin
    if (cnt_q == 6'd0) begin
      n = 6'd1;
    end else if (cnt_q > NMax) begin
      n = NMax;
    end else begin
      n = cnt_q;
    end
  end

  assign k          = n - 6'd1;
  assign started    = 32'((33'd1 << k) - 33'd1);
  assign ready_eff  = ready_q & started;
  assign none_ready = (ready_eff == 32'd0);

  assign sel_inc = {1'b0, sel_q} + 7'd1;
  assign cand    = (sel_inc >= {1'b0, n}) ? 6'd1 : sel_inc[5:0];
  assign cand_m1 = cand - 6'd1;
  assign hit     = ready_eff[cand_m1[4:0]];
  assign sel_new = none_ready ? 6'd0 : cand;

  assign walk_m1 = walk_q - 6'd1;
  assign run_m1  = run_q - 6'd1;
  assign tmo_rd  = tmo_q[walk_m1[IdxW-1:0]];

  assign stat_o.multi_thread = (n != 6'd1);
  assign stat_o.tick_last    = (walk_q == k);
  assign stat_o.delay_ok     = rv_q && (run_q != 6'd0) && (run_q < n);
  assign stat_o.sched_done   = none_ready || hit;

  always_comb begin
    ready_d = ready_q;
    if (cmd_i.tick_step && (tmo_rd == 32'd1)) begin
      ready_d[walk_m1[4:0]] = 1'b1;
    end
    if (cmd_i.delay_apply) begin
      ready_d[run_m1[4:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 6'd1;
      ready_q <= '1;
      sel_q   <= '0;
      run_q   <= '0;
      rv_q    <= 1'b0;
      sw_q    <= 1'b0;
      walk_q  <= 6'd1;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      ready_q <= ready_d;
      if (cmd_i.tick_start) begin
        walk_q <= 6'd1;
      end else if (cmd_i.tick_step) begin
        walk_q <= walk_q + 6'd1;
      end
      if (cmd_i.sw_clear) begin
        sw_q <= 1'b0;
      end
      if (cmd_i.sched_step) begin
        sel_q <= sel_new;
        if (none_ready || hit) begin
          sw_q  <= !rv_q || (run_q != sel_new);
          run_q <= sel_new;
          rv_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_THREADS); i++) begin
        tmo_q[i] <= '0;
      end
    end else begin
      if (cmd_i.tick_step && (tmo_rd != 32'd0)) begin
        tmo_q[walk_m1[IdxW-1:0]] <= tmo_rd - 32'd1;
      end
      if (cmd_i.delay_apply) begin
        tmo_q[run_m1[IdxW-1:0]] <= delay_ticks_i;
      end
    end
  end

  always_comb begin
    result_o.next_thread    = sel_q;
    result_o.switch_request = sw_q;
    result_o.ready_bits     = ready_eff;
  end

endmodule

`default_nettype wire

@@ design/round_robin_thread_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Round-robin thread scheduler unit
// RTOS-style scheduler: per-thread ready bits and timeout counters, tick,
// delay and round-robin schedule operations, one result beat per item.
//
// Channel   Ports                          Handshake
// item      item_i                         start & !busy
// result    result_o                       result_strobe_o, one cycle
// config    cfg_we_i, cfg_wdata_i          cfg_we_i
//
// Tick: walks the timeout counters one per cycle. Delay/schedule: one
// round-robin step per cycle; the search ends on its first step when no
// thread is ready. Other items go straight to the beat. busy covers the
// whole item and its beat. Reset sets all state at once, no clearing pass.
// The result beat cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_scheduler_unit #(
  parameter int unsigned MAX_THREADS = rrts_pkg::MaxThreads
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  rrts_pkg::item_t     item_i,
  output rrts_pkg::result_t   result_o,
  output logic                result_strobe_o,
  input  wire logic           cfg_we_i,
  input  wire logic [5:0]     cfg_wdata_i
);

  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;

  rrts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (item_i.func),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .strobe_o (result_strobe_o)
  );

  rrts_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .delay_ticks_i (item_i.delay_ticks),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_o      (result_o)
  );

`include "round_robin_thread_scheduler_unit_macros.svh"

  `RRTS_ASSERT_IMP(a_strobe_busy, clk_i, rst_ni, result_strobe_o, busy, "beat outside item")
  `RRTS_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept not held")
  `RRTS_ASSERT_NXT(a_one_beat, clk_i, rst_ni, result_strobe_o, !busy, "beat not final")
  `RRTS_ASSERT_IMP(a_cmd_excl, clk_i, rst_ni, 1'b1,
                   $countones({cmd.tick_step, cmd.sched_step, cmd.delay_apply}) <= 1,
                   "overlapping datapath commands")

endmodule

`default_nettype wire
